### src/rotation_matrix_to_quaternion_macros.svh
// Assertion macros for the rotation matrix to quaternion block.
// Used by the top level; expands to nothing under synthesis.
`ifndef ROTATION_MATRIX_TO_QUATERNION_MACROS_SVH
`define ROTATION_MATRIX_TO_QUATERNION_MACROS_SVH
`ifndef SYNTHESIS
`define RMQ_ASSERT_IMPL(label, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("assertion failed");
`define RMQ_ASSERT_DELAY(label, cond, n, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> ##n (prop)) \
    else $error("assertion failed");
`else
`define RMQ_ASSERT_IMPL(label, cond, prop)
`define RMQ_ASSERT_DELAY(label, cond, n, prop)
`endif
`endif

### src/rmq_pkg.sv
// Shared types and constants for the rotation matrix to quaternion block.
// No dependencies.
`timescale 1ns / 1ps
package rmq_pkg;

  localparam int SQ_STAGES = 4;
  localparam int SQ_STEPS  = 4;
  localparam int DV_STAGES = 4;
  localparam int DV_STEPS  = 4;

  localparam logic [15:0] ONE_Q14  = 16'd16384;
  localparam logic [14:0] TOL_RESET = 15'd2;

  localparam logic [1:0] AX_X = 2'd0;
  localparam logic [1:0] AX_Y = 2'd1;
  localparam logic [1:0] AX_Z = 2'd2;

  typedef logic signed [15:0] elem_t;
  typedef logic signed [16:0] num_t;

  typedef struct packed {
    elem_t m00;
    elem_t m01;
    elem_t m02;
    elem_t m10;
    elem_t m11;
    elem_t m12;
    elem_t m20;
    elem_t m21;
    elem_t m22;
  } matrix_t;

  typedef struct packed {
    elem_t quat_x;
    elem_t quat_y;
    elem_t quat_z;
    elem_t quat_w;
  } quat_t;

  typedef struct packed {
    num_t num_x;
    num_t num_y;
    num_t num_z;
    num_t num_w;
  } nums_t;

  // hsel: bit 0 x, bit 1 y, bit 2 z, bit 3 w takes the square root
  typedef struct packed {
    logic       valid;
    logic       ident;
    logic [3:0] hsel;
  } ctrl_t;

  function automatic num_t sx17(input elem_t a);
    return {a[15], a};
  endfunction

endpackage

### src/rmq_front.sv
// Input stage: row tolerance test, trace, branch select, radicand and numerators.
// Depends on rmq_pkg.
`timescale 1ns / 1ps
module rmq_front import rmq_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        valid_in,
  input  matrix_t     matrix,
  input  logic [14:0] tol,
  output ctrl_t       ctrl,
  output logic [31:0] rad,
  output nums_t       nums
);

  function automatic logic small_elem(input elem_t a, input logic [14:0] t);
    logic [16:0] mag;
    mag = a[15] ? 17'(-sx17(a)) : 17'(sx17(a));
    return mag <= {2'b00, t};
  endfunction

  logic               near0, near1, near2;
  logic signed [17:0] tr;
  logic               pos;
  logic [1:0]         isel;
  logic signed [17:0] dii;
  logic signed [18:0] s_raw;
  logic [16:0]        s_val;
  num_t               dx, dy, dz, s01, s02, s12;
  ctrl_t              ctrl_next;
  nums_t              nums_next;

  always_comb begin
    near0 = small_elem(matrix.m00, tol) && small_elem(matrix.m01, tol)
            && small_elem(matrix.m02, tol);
    near1 = small_elem(matrix.m10, tol) && small_elem(matrix.m11, tol)
            && small_elem(matrix.m12, tol);
    near2 = small_elem(matrix.m20, tol) && small_elem(matrix.m21, tol)
            && small_elem(matrix.m22, tol);
    tr = 18'(sx17(matrix.m00)) + 18'(sx17(matrix.m11)) + 18'(sx17(matrix.m22));
    pos = tr > 18'sd0;
    isel = AX_X;
    dii = 18'(sx17(matrix.m00));
    if (matrix.m11 > matrix.m00) begin
      isel = AX_Y;
      dii = 18'(sx17(matrix.m11));
    end
    if (18'(sx17(matrix.m22)) > dii) begin
      isel = AX_Z;
      dii = 18'(sx17(matrix.m22));
    end
    if (pos) begin
      s_raw = 19'(tr) + 19'sd16384;
    end else begin
      s_raw = 19'(dii) + 19'(dii) - 19'(tr) + 19'sd16384;
    end
    s_val = (s_raw < 19'sd16384) ? 17'(ONE_Q14) : s_raw[16:0];

    dx  = sx17(matrix.m12) - sx17(matrix.m21);
    dy  = sx17(matrix.m20) - sx17(matrix.m02);
    dz  = sx17(matrix.m01) - sx17(matrix.m10);
    s01 = sx17(matrix.m01) + sx17(matrix.m10);
    s02 = sx17(matrix.m02) + sx17(matrix.m20);
    s12 = sx17(matrix.m12) + sx17(matrix.m21);

    ctrl_next.valid = valid_in;
    ctrl_next.ident = near0 || near1 || near2;
    if (pos) begin
      ctrl_next.hsel = 4'b1000;
      nums_next = '{num_x: dx, num_y: dy, num_z: dz, num_w: '0};
    end else begin
      case (isel)
        AX_X: begin
          ctrl_next.hsel = 4'b0001;
          nums_next = '{num_x: '0, num_y: s01, num_z: s02, num_w: dx};
        end
        AX_Y: begin
          ctrl_next.hsel = 4'b0010;
          nums_next = '{num_x: s01, num_y: '0, num_z: s12, num_w: dy};
        end
        default: begin
          ctrl_next.hsel = 4'b0100;
          nums_next = '{num_x: s02, num_y: s12, num_z: '0, num_w: dz};
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl <= '0;
    end else begin
      ctrl <= ctrl_next;
    end
    rad  <= {3'b000, s_val, 12'h000};
    nums <= nums_next;
  end

endmodule

### src/rmq_sqrt.sv
// Pipelined digit-by-digit integer square root, two radicand bits per step.
// Depends on rmq_pkg.
`timescale 1ns / 1ps
module rmq_sqrt import rmq_pkg::*; (
  input  logic        clk,
  input  logic [31:0] rad,
  output logic [14:0] root
);

  logic [31:0] rad_q  [SQ_STAGES];
  logic [15:0] root_q [SQ_STAGES];
  logic [19:0] rem_q  [SQ_STAGES];

  for (genvar st = 0; st < SQ_STAGES; st++) begin : g_st
    logic [31:0] rad_s;
    logic [15:0] root_s;
    logic [19:0] rem_s;
    logic [15:0] root_n;
    logic [19:0] rem_n;

    if (st == 0) begin : g_first
      assign rad_s  = rad;
      assign root_s = '0;
      assign rem_s  = '0;
    end else begin : g_rest
      assign rad_s  = rad_q[st-1];
      assign root_s = root_q[st-1];
      assign rem_s  = rem_q[st-1];
    end

    always_comb begin
      logic [19:0] trial;
      root_n = root_s;
      rem_n  = rem_s;
      for (int k = 0; k < SQ_STEPS; k++) begin
        rem_n = {rem_n[17:0], rad_s[31 - 2*(SQ_STEPS*st + k) -: 2]};
        trial = {2'b00, root_n, 2'b01};
        if (rem_n >= trial) begin
          rem_n  = rem_n - trial;
          root_n = {root_n[14:0], 1'b1};
        end else begin
          root_n = {root_n[14:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      rad_q[st]  <= rad_s;
      root_q[st] <= root_n;
      rem_q[st]  <= rem_n;
    end
  end

  assign root = root_q[SQ_STAGES-1][14:0];

endmodule

### src/rmq_div.sv
// Pipelined restoring divider: rounded num * 4096 / h, positive results saturated to 16 bits.
// Depends on rmq_pkg.
`timescale 1ns / 1ps
module rmq_div import rmq_pkg::*; (
  input  logic        clk,
  input  num_t        num,
  input  logic [14:0] h,
  output elem_t       quot
);

  logic        neg_in;
  logic [16:0] mag;
  logic [30:0] dividend;

  assign neg_in   = num[16];
  assign mag      = neg_in ? 17'(-num) : 17'(num);
  assign dividend = {1'b0, mag, 13'h0000} + {16'h0000, h};

  logic [15:0] rem_q [DV_STAGES];
  logic [15:0] q_q   [DV_STAGES];
  logic [15:0] lo_q  [DV_STAGES];
  logic [15:0] den_q [DV_STAGES];
  logic        neg_q [DV_STAGES];

  for (genvar st = 0; st < DV_STAGES; st++) begin : g_st
    logic [15:0] rem_s, q_s, lo_s, den_s;
    logic        neg_s;
    logic [15:0] rem_n, q_n;

    if (st == 0) begin : g_first
      assign rem_s = {1'b0, dividend[30:16]};
      assign q_s   = '0;
      assign lo_s  = dividend[15:0];
      assign den_s = {h, 1'b0};
      assign neg_s = neg_in;
    end else begin : g_rest
      assign rem_s = rem_q[st-1];
      assign q_s   = q_q[st-1];
      assign lo_s  = lo_q[st-1];
      assign den_s = den_q[st-1];
      assign neg_s = neg_q[st-1];
    end

    always_comb begin
      logic [16:0] r2;
      rem_n = rem_s;
      q_n   = q_s;
      for (int k = 0; k < DV_STEPS; k++) begin
        r2 = {rem_n, lo_s[15 - (DV_STEPS*st + k)]};
        if (r2 >= {1'b0, den_s}) begin
          r2  = r2 - {1'b0, den_s};
          q_n = {q_n[14:0], 1'b1};
        end else begin
          q_n = {q_n[14:0], 1'b0};
        end
        rem_n = r2[15:0];
      end
    end

    always_ff @(posedge clk) begin
      rem_q[st] <= rem_n;
      q_q[st]   <= q_n;
      lo_q[st]  <= lo_s;
      den_q[st] <= den_s;
      neg_q[st] <= neg_s;
    end
  end

  logic [15:0] q_last;
  logic [16:0] q_neg;

  assign q_last = q_q[DV_STAGES-1];
  assign q_neg  = -{1'b0, q_last};

  always_comb begin
    if (neg_q[DV_STAGES-1]) begin
      quot = q_neg[15:0];
    end else if (q_last[15]) begin
      quot = 16'sh7fff;
    end else begin
      quot = q_last;
    end
  end

endmodule

### src/rotation_matrix_to_quaternion.sv
// A matrix taken at a start edge passes the front, square-root, divider and output
// registers to give its quaternion with done high. Throughput: one matrix per cycle; busy stays low.
// Depth is set by the square-root pipeline (four stages) and divider (four stages).
// The receiver cannot stall: each result is shown for one cycle only.
// Synchronous reset clears all valid bits and sets the tolerance register tol to 2.
`timescale 1ns / 1ps
`include "rotation_matrix_to_quaternion_macros.svh"
module rotation_matrix_to_quaternion import rmq_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  matrix_t     matrix,
  output logic        done,
  output quat_t       quat,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [14:0] cfg_data
);

  localparam int CTRL_DEPTH = SQ_STAGES + DV_STAGES;
  localparam int LAT        = CTRL_DEPTH + 2;

  logic [14:0] tol;
  ctrl_t       ctrl0;
  logic [31:0] rad;
  nums_t       nums0;
  logic [14:0] root;
  ctrl_t       ctrl_d [CTRL_DEPTH];
  nums_t       nums_d [SQ_STAGES];
  logic [14:0] root_d [DV_STAGES];
  elem_t       qx, qy, qz, qw;
  ctrl_t       ctrl_o;
  logic [14:0] root_o;
  elem_t       h_o;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      tol <= TOL_RESET;
    end else if (cfg_valid && cfg_ready) begin
      tol <= cfg_data;
    end
  end

  rmq_front u_front (
    .clk      (clk),
    .rst      (rst),
    .valid_in (start && !busy),
    .matrix   (matrix),
    .tol      (tol),
    .ctrl     (ctrl0),
    .rad      (rad),
    .nums     (nums0)
  );

  rmq_sqrt u_sqrt (
    .clk  (clk),
    .rad  (rad),
    .root (root)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CTRL_DEPTH; i++) begin
        ctrl_d[i] <= '0;
      end
    end else begin
      ctrl_d[0] <= ctrl0;
      for (int i = 1; i < CTRL_DEPTH; i++) begin
        ctrl_d[i] <= ctrl_d[i-1];
      end
    end
    nums_d[0] <= nums0;
    for (int i = 1; i < SQ_STAGES; i++) begin
      nums_d[i] <= nums_d[i-1];
    end
    root_d[0] <= root;
    for (int i = 1; i < DV_STAGES; i++) begin
      root_d[i] <= root_d[i-1];
    end
  end

  // sqrt output lines up with nums_d[SQ_STAGES-1] (both behind the front reg)
  rmq_div u_div_x (.clk(clk), .num(nums_d[SQ_STAGES-1].num_x), .h(root), .quot(qx));
  rmq_div u_div_y (.clk(clk), .num(nums_d[SQ_STAGES-1].num_y), .h(root), .quot(qy));
  rmq_div u_div_z (.clk(clk), .num(nums_d[SQ_STAGES-1].num_z), .h(root), .quot(qz));
  rmq_div u_div_w (.clk(clk), .num(nums_d[SQ_STAGES-1].num_w), .h(root), .quot(qw));

  assign ctrl_o = ctrl_d[CTRL_DEPTH-1];
  assign root_o = root_d[DV_STAGES-1];
  assign h_o    = {1'b0, root_o};

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ctrl_o.valid;
    end
    if (ctrl_o.ident) begin
      quat <= '{quat_x: '0, quat_y: '0, quat_z: '0, quat_w: ONE_Q14};
    end else begin
      quat.quat_x <= ctrl_o.hsel[0] ? h_o : qx;
      quat.quat_y <= ctrl_o.hsel[1] ? h_o : qy;
      quat.quat_z <= ctrl_o.hsel[2] ? h_o : qz;
      quat.quat_w <= ctrl_o.hsel[3] ? h_o : qw;
    end
  end

  `RMQ_ASSERT_DELAY(a_start_done, start && !busy, LAT, done)
  `RMQ_ASSERT_DELAY(a_idle_quiet, !start, LAT, !done)
  `RMQ_ASSERT_IMPL(a_root_floor, ctrl_o.valid && !ctrl_o.ident, root_o >= 15'd8192)
  `RMQ_ASSERT_IMPL(a_hsel_one, ctrl_o.valid, $onehot(ctrl_o.hsel))

endmodule

### verif/testbench.sv
// Self-checking testbench for rotation_matrix_to_quaternion: drives matrices
// through the start/busy port and compares each quaternion against a local model.
// Depends on rmq_pkg and the rotation_matrix_to_quaternion RTL.
`timescale 1ns / 1ps
module testbench;
  import rmq_pkg::*;

  localparam int LATENCY = 12;
  localparam int WATCHDOG = 2000;
  localparam int N_RANDOM = 950;

  typedef struct {
    matrix_t m;
    logic    has_quat;
    quat_t   q;
  } stim_row_t;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  matrix_t     matrix;
  logic        done;
  quat_t       quat;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [14:0] cfg_data;

  logic [14:0] tolerance;
  quat_t       pending_quats[$];
  stim_row_t   rows[$];
  int          errors;
  int          idle_cycles;

  rotation_matrix_to_quaternion uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .matrix(matrix),
    .done(done), .quat(quat), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned root;
    longint unsigned bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= root + bitv) begin
        v -= root + bitv;
        root = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    return root;
  endfunction

  function automatic elem_t clamp16(longint v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return 16'sh8000;
    return elem_t'(v);
  endfunction

  function automatic elem_t ratio_q14(longint d, longint unsigned h);
    longint unsigned mag;
    longint q;
    mag = (d < 0 ? -d : d) * 4096;
    q = longint'((mag * 2 + h) / (h * 2));
    return clamp16(d < 0 ? -q : q);
  endfunction

  function automatic logic row_is_zero(elem_t a, elem_t b, elem_t c);
    longint t;
    t = tolerance;
    return (a < 0 ? -longint'(a) : a) <= t && (b < 0 ? -longint'(b) : b) <= t &&
           (c < 0 ? -longint'(c) : c) <= t;
  endfunction

  function automatic quat_t shepperd_quat(matrix_t mt);
    longint m[3][3];
    longint comp[4];
    longint tr;
    longint s;
    longint unsigned h;
    int i;
    int j;
    int k;
    quat_t r;
    m[0][0] = mt.m00; m[0][1] = mt.m01; m[0][2] = mt.m02;
    m[1][0] = mt.m10; m[1][1] = mt.m11; m[1][2] = mt.m12;
    m[2][0] = mt.m20; m[2][1] = mt.m21; m[2][2] = mt.m22;
    if (row_is_zero(mt.m00, mt.m01, mt.m02) || row_is_zero(mt.m10, mt.m11, mt.m12) ||
        row_is_zero(mt.m20, mt.m21, mt.m22)) begin
      r.quat_x = '0;
      r.quat_y = '0;
      r.quat_z = '0;
      r.quat_w = ONE_Q14;
      return r;
    end
    tr = m[0][0] + m[1][1] + m[2][2];
    if (tr > 0) begin
      h = int_sqrt(longint'(tr + 16384) * 4096);
      r.quat_w = clamp16(h);
      r.quat_x = ratio_q14(m[1][2] - m[2][1], h);
      r.quat_y = ratio_q14(m[2][0] - m[0][2], h);
      r.quat_z = ratio_q14(m[0][1] - m[1][0], h);
      return r;
    end
    i = AX_X;
    if (m[1][1] > m[0][0]) i = AX_Y;
    if (m[2][2] > m[i][i]) i = AX_Z;
    j = (i + 1) % 3;
    k = (j + 1) % 3;
    s = m[i][i] - m[j][j] - m[k][k] + 16384;
    if (s < 16384) s = 16384;
    h = int_sqrt(s * 4096);
    comp[i] = clamp16(h);
    comp[3] = ratio_q14(m[j][k] - m[k][j], h);
    comp[j] = ratio_q14(m[i][j] + m[j][i], h);
    comp[k] = ratio_q14(m[i][k] + m[k][i], h);
    r.quat_x = elem_t'(comp[0]);
    r.quat_y = elem_t'(comp[1]);
    r.quat_z = elem_t'(comp[2]);
    r.quat_w = elem_t'(comp[3]);
    return r;
  endfunction

  function automatic matrix_t make_matrix(int a, int b, int c, int d, int e, int f,
                                          int g, int h, int i);
    matrix_t m;
    m = '{elem_t'(a), elem_t'(b), elem_t'(c), elem_t'(d), elem_t'(e), elem_t'(f),
          elem_t'(g), elem_t'(h), elem_t'(i)};
    return m;
  endfunction

  function automatic quat_t make_quat(int x, int y, int z, int w);
    quat_t q;
    q = '{elem_t'(x), elem_t'(y), elem_t'(z), elem_t'(w)};
    return q;
  endfunction

  function automatic void queue_expected(quat_t q);
    pending_quats.insert(pending_quats.size(), q);
  endfunction

  function automatic void add_row(matrix_t m, logic has_quat, quat_t q);
    stim_row_t row;
    row.m = m;
    row.has_quat = has_quat;
    row.q = q;
    rows.insert(rows.size(), row);
  endfunction

  function automatic elem_t rand_elem(int mode);
    case (mode)
      0: return elem_t'($urandom);
      1: return elem_t'($urandom_range(0, 32767) - 16384);
      2: return elem_t'($urandom_range(0, 8) - 4);
      default: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
    endcase
  endfunction

  function automatic matrix_t rand_matrix();
    matrix_t m;
    elem_t e[9];
    int zrow;
    for (int n = 0; n < 9; n++) begin
      e[n] = rand_elem($urandom_range(0, 9) < 6 ? 1 : $urandom_range(0, 3));
    end
    if ($urandom_range(0, 9) == 0) begin
      zrow = $urandom_range(0, 2);
      for (int n = 0; n < 3; n++) e[zrow * 3 + n] = rand_elem(2);
    end
    m = '{e[0], e[1], e[2], e[3], e[4], e[5], e[6], e[7], e[8]};
    return m;
  endfunction

  // hold start high; the caller drops it when the stream pauses
  task automatic send_matrix(matrix_t m);
    start <= 1'b1;
    matrix <= m;
    do @(posedge clk); while (busy);
    queue_expected(shepperd_quat(m));
  endtask

  task automatic drain();
    start <= 1'b0;
    while (pending_quats.size() != 0) @(posedge clk);
    repeat (LATENCY) @(posedge clk);
  endtask

  task automatic write_tolerance(logic [14:0] value);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    tolerance = value;
    cfg_valid <= 1'b0;
  endtask

  always @(posedge clk) begin
    quat_t exp_q;
    if (!rst && done) begin
      if (pending_quats.size() == 0) begin
        $error("unexpected quaternion %h", quat);
        errors++;
      end else begin
        exp_q = pending_quats.pop_front();
        if (quat.quat_x !== exp_q.quat_x) begin
          $error("quat_x expected %0d actual %0d", exp_q.quat_x, quat.quat_x);
          errors++;
        end
        if (quat.quat_y !== exp_q.quat_y) begin
          $error("quat_y expected %0d actual %0d", exp_q.quat_y, quat.quat_y);
          errors++;
        end
        if (quat.quat_z !== exp_q.quat_z) begin
          $error("quat_z expected %0d actual %0d", exp_q.quat_z, quat.quat_z);
          errors++;
        end
        if (quat.quat_w !== exp_q.quat_w) begin
          $error("quat_w expected %0d actual %0d", exp_q.quat_w, quat.quat_w);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG) begin
      $display("FAIL rotation_matrix_to_quaternion");
      $finish;
    end
  end

  initial begin
    logic [14:0] tol_set[4];
    int gap_pct;
    rst = 1'b1;
    start = 1'b0;
    matrix = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    errors = 0;
    idle_cycles = 0;
    tolerance = TOL_RESET;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    add_row(make_matrix(16384, 0, 0, 0, 16384, 0, 0, 0, 16384), 1'b1,
            make_quat(0, 0, 0, 16384));
    add_row(make_matrix(2, -2, 0, 16384, 0, 0, 0, 0, 16384), 1'b1,
            make_quat(0, 0, 0, 16384));
    add_row(make_matrix(16384, 0, 0, 0, 16384, 0, 1, -1, 2), 1'b1,
            make_quat(0, 0, 0, 16384));
    add_row(make_matrix(3, 0, 0, 0, 16384, 0, 0, 0, 16384), 1'b0, '0);
    add_row(make_matrix(0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1,
            make_quat(0, 0, 0, 16384));
    add_row(make_matrix(16384, 0, 0, 0, -16384, 0, 0, 0, -16384), 1'b0, '0);
    add_row(make_matrix(-16384, 0, 0, 0, 16384, 0, 0, 0, -16384), 1'b0, '0);
    add_row(make_matrix(-16384, 0, 0, 0, -16384, 0, 0, 0, 16384), 1'b0, '0);
    add_row(make_matrix(0, 16384, 0, 16384, 0, 0, 0, 0, -16384), 1'b0, '0);
    add_row(make_matrix(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767,
                        32767), 1'b0, '0);
    add_row(make_matrix(-32768, -32768, -32768, -32768, -32768, -32768, -32768,
                        -32768, -32768), 1'b0, '0);
    add_row(make_matrix(1, 32767, -32768, -32768, 1, 32767, 32767, -32768, 1),
            1'b0, '0);
    add_row(make_matrix(-32768, 32767, 32767, 32767, -32768, 32767, 32767, 32767,
                        -32768), 1'b0, '0);
    add_row(make_matrix(0, -16384, 0, 16384, 0, 0, 0, 0, 16384), 1'b0, '0);
    add_row(make_matrix(-5, 9000, 100, -9000, -5, 7, 3, 100, 10), 1'b0, '0);
    add_row(make_matrix(0, 5, 7, 5, 0, 9, 7, 9, 0), 1'b0, '0);

    foreach (rows[n]) begin
      send_matrix(rows[n].m);
      if (rows[n].has_quat) begin
        pending_quats[pending_quats.size() - 1] = rows[n].q;
      end
    end
    drain();

    tol_set = '{15'd0, 15'd32767, 15'd100, 15'd6000};
    for (int phase = 0; phase < 4; phase++) begin
      write_tolerance(tol_set[phase]);
      for (int n = 0; n < N_RANDOM / 4; n++) begin
        gap_pct = (phase == 1) ? 0 : 23;
        while ($urandom_range(0, 99) < gap_pct) begin
          start <= 1'b0;
          @(posedge clk);
        end
        if (n == N_RANDOM / 8) drain();
        send_matrix(rand_matrix());
      end
      drain();
    end
    write_tolerance(TOL_RESET);
    send_matrix(make_matrix(1, 2, 0, 16384, 0, 0, 0, 0, 16384));
    drain();

    if (errors == 0) begin
      $display("PASS rotation_matrix_to_quaternion");
    end else begin
      $display("FAIL rotation_matrix_to_quaternion");
    end
    $finish;
  end

endmodule
